// ===== rtl/um32_pkg.sv =====
package um32_pkg;

	localparam int SEGMENTS_DEF  = 16;
	localparam int SEG_WORDS_DEF = 1024;

	localparam int OPC_LSB   = 28;
	localparam int LDI_LSB   = 25;
	localparam int IMM_W     = 25;
	localparam int BYTE_MAX  = 255;
	localparam int DIV_STEPS = 32;

	typedef enum logic [3:0] {
		OP_CMOV  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_STORE = 4'd2,
		OP_ADD   = 4'd3,
		OP_MUL   = 4'd4,
		OP_DIV   = 4'd5,
		OP_NAND  = 4'd6,
		OP_HALT  = 4'd7,
		OP_MAP   = 4'd8,
		OP_UNMAP = 4'd9,
		OP_OUT   = 4'd10,
		OP_IN    = 4'd11,
		OP_LOADP = 4'd12,
		OP_LDI   = 4'd13
	} opcode_t;

	localparam logic [3:0] F_NONE     = 4'd0;
	localparam logic [3:0] F_OPCODE   = 4'd1;
	localparam logic [3:0] F_PC       = 4'd2;
	localparam logic [3:0] F_OUT      = 4'd3;
	localparam logic [3:0] F_DIV      = 4'd4;
	localparam logic [3:0] F_UNMAPPED = 4'd5;
	localparam logic [3:0] F_OFFSET   = 4'd6;
	localparam logic [3:0] F_UNMAP    = 4'd7;
	localparam logic [3:0] F_CAPACITY = 4'd8;

	typedef enum logic [1:0] {
		RS_A,
		RS_B,
		RS_C
	} rsel_t;

	typedef struct packed {
		logic       accept;
		logic       append;
		logic       fetch;
		logic       ld_instr;
		rsel_t      rsel;
		logic       ld_op;
		logic       commit;
		logic       raise;
		logic [3:0] raise_code;
		logic       mem_rd;
		logic       mem_wr;
		logic       div_start;
		logic       div_step;
		logic       loop_init;
		logic       fill_wr;
		logic       copy_rd;
		logic       copy_wr;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic       stopped;
		logic       command;
		logic       full0;
		logic       pc_bad;
		opcode_t    op;
		logic [3:0] exe_fault;
		logic       div_done;
		logic       loop_done;
	} status_t;

endpackage

// ===== rtl/um32_ram.sv =====
module um32_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/um32_ctrl.sv =====
module um32_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output um32_pkg::cmd_t    cmd,
	input  um32_pkg::status_t status
);
	import um32_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_RB,
		S_RC,
		S_RA,
		S_EXEC,
		S_LDW,
		S_DIV,
		S_FILL,
		S_CPR,
		S_CPW,
		S_DONE
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		cmd.rsel = RS_A;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = S_DONE;
					if (!status.stopped) begin
						if (!status.command) begin
							if (status.full0) begin
								cmd.raise      = 1'b1;
								cmd.raise_code = F_CAPACITY;
							end else begin
								cmd.append = 1'b1;
							end
						end else if (status.pc_bad) begin
							cmd.raise      = 1'b1;
							cmd.raise_code = F_PC;
						end else begin
							cmd.fetch = 1'b1;
							state_d   = S_FETCH;
						end
					end
				end
			end
			S_FETCH: begin
				cmd.ld_instr = 1'b1;
				state_d      = S_RB;
			end
			S_RB: begin
				cmd.rsel  = RS_B;
				cmd.ld_op = 1'b1;
				state_d   = S_RC;
			end
			S_RC: begin
				cmd.rsel  = RS_C;
				cmd.ld_op = 1'b1;
				state_d   = S_RA;
			end
			S_RA: begin
				cmd.rsel  = RS_A;
				cmd.ld_op = 1'b1;
				state_d   = S_EXEC;
			end
			S_EXEC: begin
				if (status.exe_fault != F_NONE) begin
					cmd.raise      = 1'b1;
					cmd.raise_code = status.exe_fault;
					state_d        = S_DONE;
				end else begin
					case (status.op)
						OP_LOAD: begin
							cmd.mem_rd = 1'b1;
							state_d    = S_LDW;
						end
						OP_STORE: begin
							cmd.mem_wr = 1'b1;
							cmd.commit = 1'b1;
							state_d    = S_DONE;
						end
						OP_DIV: begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
						OP_MAP: begin
							cmd.commit    = 1'b1;
							cmd.loop_init = 1'b1;
							state_d       = S_FILL;
						end
						OP_LOADP: begin
							cmd.commit    = 1'b1;
							cmd.loop_init = 1'b1;
							state_d       = S_CPR;
						end
						default: begin
							cmd.commit = 1'b1;
							state_d    = S_DONE;
						end
					endcase
				end
			end
			S_LDW: begin
				cmd.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DIV: begin
				if (status.div_done) begin
					cmd.commit = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_FILL: begin
				if (status.loop_done) begin
					state_d = S_DONE;
				end else begin
					cmd.fill_wr = 1'b1;
				end
			end
			S_CPR: begin
				if (status.loop_done) begin
					state_d = S_DONE;
				end else begin
					cmd.copy_rd = 1'b1;
					state_d     = S_CPW;
				end
			end
			S_CPW: begin
				cmd.copy_wr = 1'b1;
				state_d     = S_CPR;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_finish_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> !cmd.finish) else $error("result strobe held");
	a_commit_xor_raise: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && cmd.raise)) else $error("commit with fault");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("transfer not taken");
endmodule

// ===== rtl/um32_datapath.sv =====
module um32_datapath #(
	parameter int SEGMENTS  = um32_pkg::SEGMENTS_DEF,
	parameter int SEG_WORDS = um32_pkg::SEG_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  um32_pkg::cmd_t    cmd,
	output um32_pkg::status_t status,
	input  logic              command,
	input  logic [31:0]       program_word,
	input  logic [7:0]        in_byte,
	input  logic              in_eof,
	output logic              done,
	output logic              out_valid,
	output logic [7:0]        out_byte,
	output logic              input_taken,
	output logic              halted,
	output logic [3:0]        fault,
	output logic [31:0]       next_pc
);
	import um32_pkg::*;

	localparam int SIW   = $clog2(SEGMENTS);
	localparam int CW    = $clog2(SEGMENTS + 1);
	localparam int OW    = $clog2(SEG_WORDS);
	localparam int LW    = $clog2(SEG_WORDS + 1);
	localparam int DEPTH = SEGMENTS * SEG_WORDS;
	localparam int AW    = $clog2(DEPTH);

	// architectural state
	logic [31:0]         rf_q [8];
	logic [31:0]         pc_q;
	logic                stopped_q;
	logic [3:0]          fault_q;
	logic [SEGMENTS-1:0] mapped_q;
	logic [LW-1:0]       len_q [SEGMENTS];
	logic [SIW-1:0]      stack_q [SEGMENTS];
	logic [CW-1:0]       free_cnt_q;
	logic [CW-1:0]       fresh_q;
	logic                ov_q, it_q;
	logic [7:0]          ob_q;

	// working registers
	logic [7:0]    byte_q;
	logic          eof_q;
	logic [31:0]   instr_q, opa_q, opb_q, opc_q;
	logic [31:0]   rem_q;
	logic [31:0]   quo_q;
	logic [5:0]    dcnt_q;
	logic [LW-1:0] loop_cnt_q, loop_n_q;
	logic [AW-1:0] loop_base_q;

	logic [31:0] rdata;
	opcode_t     op;
	logic [2:0]  ra, rb, rc;

	assign op = opcode_t'(instr_q[31:OPC_LSB]);
	assign ra = instr_q[8:6];
	assign rb = instr_q[5:3];
	assign rc = instr_q[2:0];

	// register file, one read port
	logic [2:0]  rs_idx;
	logic [31:0] rf_rd;
	always_comb begin
		case (cmd.rsel)
			RS_A:    rs_idx = ra;
			RS_B:    rs_idx = rb;
			default: rs_idx = rc;
		endcase
	end
	assign rf_rd = rf_q[rs_idx];

	// segment table lookup, one id per instruction
	logic [31:0]    sid, off;
	logic           sid_ok, map_sel, off_bad;
	logic [SIW-1:0] sidx;
	logic [LW-1:0]  len_sel;
	logic [3:0]     acc_fault;
	logic [AW-1:0]  seg_addr;

	assign sid     = (op == OP_STORE) ? opa_q : ((op == OP_UNMAP) ? opc_q : opb_q);
	assign off     = (op == OP_STORE) ? opb_q : opc_q;
	assign sid_ok  = sid < 32'(SEGMENTS);
	assign sidx    = sid[SIW-1:0];
	assign map_sel = sid_ok && mapped_q[sidx];
	assign len_sel = sid_ok ? len_q[sidx] : '0;
	assign off_bad = off >= 32'(len_sel);
	assign acc_fault = !map_sel ? F_UNMAPPED : (off_bad ? F_OFFSET : F_NONE);
	assign seg_addr  = AW'(sidx) * AW'(SEG_WORDS) + AW'(off[OW-1:0]);

	// id allocation: freed ids first, last in first out
	logic [CW-1:0]  cnt_m1;
	logic [SIW-1:0] map_id;
	logic [3:0]     map_fault;
	assign cnt_m1 = free_cnt_q - CW'(1);
	assign map_id = (free_cnt_q != '0) ? stack_q[cnt_m1[SIW-1:0]] : fresh_q[SIW-1:0];
	assign map_fault = (opc_q > 32'(SEG_WORDS)) ? F_CAPACITY :
		((free_cnt_q == '0 && fresh_q >= CW'(SEGMENTS)) ? F_CAPACITY : F_NONE);

	logic [3:0] exe_fault;
	always_comb begin
		case (op)
			OP_LOAD, OP_STORE: exe_fault = acc_fault;
			OP_DIV:   exe_fault = (opc_q == '0) ? F_DIV : F_NONE;
			OP_MAP:   exe_fault = map_fault;
			OP_UNMAP: exe_fault = (opc_q == '0 || !map_sel) ? F_UNMAP :
				((free_cnt_q >= CW'(SEGMENTS)) ? F_CAPACITY : F_NONE);
			OP_OUT:   exe_fault = (opc_q > 32'(BYTE_MAX)) ? F_OUT : F_NONE;
			OP_LOADP: exe_fault = (opb_q != '0 && !map_sel) ? F_UNMAPPED : F_NONE;
			OP_CMOV, OP_ADD, OP_MUL, OP_NAND, OP_HALT, OP_IN, OP_LDI:
				exe_fault = F_NONE;
			default:  exe_fault = F_OPCODE;
		endcase
	end

	assign status.stopped   = stopped_q;
	assign status.command   = command;
	assign status.full0     = len_q[0] >= LW'(SEG_WORDS);
	assign status.pc_bad    = pc_q >= 32'(len_q[0]);
	assign status.op        = op;
	assign status.exe_fault = exe_fault;
	assign status.div_done  = (dcnt_q == '0);
	assign status.loop_done = (loop_cnt_q == loop_n_q);

	// word store
	logic          we, re;
	logic [AW-1:0] waddr, raddr, loop_addr;
	logic [31:0]   wdata;
	logic [LW-1:0] len0;
	assign len0      = len_q[0];
	assign loop_addr = loop_base_q + AW'(loop_cnt_q);
	assign we = cmd.append | cmd.mem_wr | cmd.fill_wr | cmd.copy_wr;
	assign re = cmd.fetch | cmd.mem_rd | cmd.copy_rd;

	always_comb begin
		waddr = AW'(loop_cnt_q);
		wdata = rdata;
		if (cmd.append) begin
			waddr = AW'(len0[OW-1:0]);
			wdata = program_word;
		end else if (cmd.mem_wr) begin
			waddr = seg_addr;
			wdata = opc_q;
		end else if (cmd.fill_wr) begin
			waddr = loop_addr;
			wdata = '0;
		end
		if (cmd.fetch) begin
			raddr = AW'(pc_q[OW-1:0]);
		end else if (cmd.mem_rd) begin
			raddr = seg_addr;
		end else begin
			raddr = loop_addr;
		end
	end

	um32_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// register writeback
	logic        rf_we;
	logic [2:0]  rf_wa;
	logic [31:0] rf_wd, mul_lo;
	assign mul_lo = opb_q * opc_q;
	always_comb begin
		rf_we = 1'b1;
		rf_wa = ra;
		rf_wd = '0;
		case (op)
			OP_CMOV: begin
				rf_we = (opc_q != '0);
				rf_wd = opb_q;
			end
			OP_LOAD: rf_wd = rdata;
			OP_ADD:  rf_wd = opb_q + opc_q;
			OP_MUL:  rf_wd = mul_lo;
			OP_DIV:  rf_wd = quo_q;
			OP_NAND: rf_wd = ~(opb_q & opc_q);
			OP_MAP: begin
				rf_wa = rb;
				rf_wd = 32'(map_id);
			end
			OP_IN: begin
				rf_wa = rc;
				rf_wd = eof_q ? '1 : 32'(byte_q);
			end
			OP_LDI: begin
				rf_wa = instr_q[LDI_LSB+2:LDI_LSB];
				rf_wd = 32'(instr_q[IMM_W-1:0]);
			end
			default: rf_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				rf_q[i] <= '0;
			end
		end else if (cmd.commit && rf_we) begin
			rf_q[rf_wa] <= rf_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			stopped_q   <= 1'b0;
			fault_q     <= F_NONE;
			mapped_q    <= SEGMENTS'(1);
			for (int i = 0; i < SEGMENTS; i++) begin
				len_q[i] <= '0;
			end
			free_cnt_q  <= '0;
			fresh_q     <= CW'(1);
			ov_q        <= 1'b0;
			ob_q        <= '0;
			it_q        <= 1'b0;
			done        <= 1'b0;
			out_valid   <= 1'b0;
			out_byte    <= '0;
			input_taken <= 1'b0;
			halted      <= 1'b0;
			fault       <= F_NONE;
			next_pc     <= '0;
		end else begin
			if (cmd.accept) begin
				ov_q <= 1'b0;
				ob_q <= '0;
				it_q <= 1'b0;
			end
			if (cmd.raise) begin
				stopped_q <= 1'b1;
				fault_q   <= cmd.raise_code;
			end
			if (cmd.append) begin
				len_q[0] <= len0 + LW'(1);
			end
			if (cmd.commit) begin
				pc_q <= (op == OP_LOADP) ? opc_q : pc_q + 32'd1;
				case (op)
					OP_HALT: stopped_q <= 1'b1;
					OP_MAP: begin
						mapped_q[map_id] <= 1'b1;
						len_q[map_id]    <= opc_q[LW-1:0];
						if (free_cnt_q != '0) begin
							free_cnt_q <= cnt_m1;
						end else begin
							fresh_q <= fresh_q + CW'(1);
						end
					end
					OP_UNMAP: begin
						mapped_q[sidx] <= 1'b0;
						len_q[sidx]    <= '0;
						free_cnt_q     <= free_cnt_q + CW'(1);
					end
					OP_OUT: begin
						ov_q <= 1'b1;
						ob_q <= opc_q[7:0];
					end
					OP_IN: it_q <= 1'b1;
					OP_LOADP: begin
						if (opb_q != '0) begin
							len_q[0] <= len_sel;
						end
					end
					default: ;
				endcase
			end
			done <= cmd.finish;
			if (cmd.finish) begin
				out_valid   <= ov_q;
				out_byte    <= ob_q;
				input_taken <= it_q;
				halted      <= stopped_q;
				fault       <= fault_q;
				next_pc     <= pc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && op == OP_UNMAP) begin
			stack_q[free_cnt_q[SIW-1:0]] <= sidx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= in_byte;
			eof_q  <= in_eof;
		end
		if (cmd.ld_instr) begin
			instr_q <= rdata;
		end
		if (cmd.ld_op) begin
			case (cmd.rsel)
				RS_A:    opa_q <= rf_rd;
				RS_B:    opb_q <= rf_rd;
				default: opc_q <= rf_rd;
			endcase
		end
		// restoring divider, one quotient bit per cycle; remainder stays below divisor
		if (cmd.div_start) begin
			rem_q  <= '0;
			quo_q  <= opb_q;
			dcnt_q <= 6'(DIV_STEPS);
		end else if (cmd.div_step) begin
			if ({rem_q, quo_q[31]} >= {1'b0, opc_q}) begin
				rem_q <= 32'({rem_q, quo_q[31]} - {1'b0, opc_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
			dcnt_q <= dcnt_q - 6'd1;
		end
		if (cmd.loop_init) begin
			loop_cnt_q <= '0;
			if (op == OP_MAP) begin
				loop_n_q    <= opc_q[LW-1:0];
				loop_base_q <= AW'(map_id) * AW'(SEG_WORDS);
			end else begin
				loop_n_q    <= (opb_q == '0) ? '0 : len_sel;
				loop_base_q <= AW'(sidx) * AW'(SEG_WORDS);
			end
		end else if (cmd.fill_wr || cmd.copy_wr) begin
			loop_cnt_q <= loop_cnt_q + LW'(1);
		end
	end

	a_sticky_stop: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q) else $error("stop released");
	a_fault_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(fault_q != F_NONE) |-> stopped_q) else $error("fault without stop");
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q < CW'(SEGMENTS)) else $error("free id count overflow");
endmodule

// ===== rtl/um32_instruction_executor.sv =====
// UM-32 machine, one command per transfer on start/busy, one result strobe per command.
// A program word load or a stopped machine goes straight to the result strobe. Any other
// instruction passes fetch, operand reads, execute and strobe; segment load adds a read
// wait, divide one quotient bit per cycle, map an n-word zero fill, load program an n-word copy.
// Throughput: one command at a time; busy holds off start until the strobe cycle.
// Async active-low reset clears registers, segment table and status; word store is unset.
module um32_instruction_executor #(
	parameter int SEGMENTS  = um32_pkg::SEGMENTS_DEF,
	parameter int SEG_WORDS = um32_pkg::SEG_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] program_word,
	input  logic [7:0]  in_byte,
	input  logic        in_eof,
	output logic        done,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        input_taken,
	output logic        halted,
	output logic [3:0]  fault,
	output logic [31:0] next_pc
);
	import um32_pkg::*;

	// controller sequences fetch, operand reads, execute and segment walks;
	// datapath owns all machine state and the word store
	cmd_t    cmd;
	status_t status;

	um32_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	um32_datapath #(
		.SEGMENTS  (SEGMENTS),
		.SEG_WORDS (SEG_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.command      (command),
		.program_word (program_word),
		.in_byte      (in_byte),
		.in_eof       (in_eof),
		.done         (done),
		.out_valid    (out_valid),
		.out_byte     (out_byte),
		.input_taken  (input_taken),
		.halted       (halted),
		.fault        (fault),
		.next_pc      (next_pc)
	);
endmodule

// ===== tb/um32_instruction_executor_test.sv =====
module um32_instruction_executor_test;
	timeunit 1ns;
	timeprecision 1ps;

	import um32_pkg::*;

	// machine size matches the block's default parameters
	localparam int SEGS  = SEGMENTS_DEF;
	localparam int SEGW  = SEG_WORDS_DEF;
	localparam int IMM_MAX = (1 << IMM_W) - 1;
	localparam int RANDOM_ITEMS = 850;
	localparam int CYCLE_LIMIT  = 1500000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [31:0] program_word;
	logic [7:0]  in_byte;
	logic        in_eof;
	logic        done;
	logic        out_valid;
	logic [7:0]  out_byte;
	logic        input_taken;
	logic        halted;
	logic [3:0]  fault;
	logic [31:0] next_pc;

	// one result strobe worth of outputs
	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        input_taken;
		logic        halted;
		logic [3:0]  fault;
		logic [31:0] next_pc;
	} um_result_t;

	// Machine mirror plus the queue of results it predicts.
	// State is public: the stimulus side steers instructions away from faults with it.
	class um32_scoreboard;
		bit [31:0]   regs [8];
		bit [31:0]   words [SEGS*SEGW];
		bit          seg_mapped [SEGS];
		int unsigned seg_len [SEGS];
		int unsigned free_ids [SEGS];
		int unsigned free_cnt;
		int unsigned fresh_id;
		bit [31:0]   pc;
		bit          stopped;
		bit [3:0]    fcode;
		um_result_t  pending [$];
		int          mismatches;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (seg_mapped[i]) begin
				seg_mapped[i] = 1'b0;
				seg_len[i] = 0;
			end
			seg_mapped[0] = 1'b1;
			free_cnt = 0;
			fresh_id = 1;
			pc = '0;
			stopped = 1'b0;
			fcode = F_NONE;
			mismatches = 0;
		endfunction

		function bit [3:0] access_fault(bit [31:0] seg, bit [31:0] off);
			if (seg >= SEGS || !seg_mapped[seg])
				return F_UNMAPPED;
			if (off >= seg_len[seg])
				return F_OFFSET;
			return F_NONE;
		endfunction

		// runs one instruction word; returns fault code, pc handled here
		function bit [3:0] run_word(bit [31:0] w, bit [7:0] ib, bit eof,
				output bit ov, output bit [7:0] ob, output bit it);
			bit [2:0] a, b, c;
			bit [3:0] f;
			int unsigned id, n;
			a = w[8:6];
			b = w[5:3];
			c = w[2:0];
			ov = 1'b0;
			ob = '0;
			it = 1'b0;
			case (w[31:28])
				OP_CMOV: if (regs[c] != 0) regs[a] = regs[b];
				OP_LOAD: begin
					f = access_fault(regs[b], regs[c]);
					if (f != F_NONE) return f;
					regs[a] = words[regs[b]*SEGW + regs[c]];
				end
				OP_STORE: begin
					f = access_fault(regs[a], regs[b]);
					if (f != F_NONE) return f;
					words[regs[a]*SEGW + regs[b]] = regs[c];
				end
				OP_ADD:  regs[a] = regs[b] + regs[c];
				OP_MUL:  regs[a] = regs[b] * regs[c];
				OP_DIV: begin
					if (regs[c] == 0) return F_DIV;
					regs[a] = regs[b] / regs[c];
				end
				OP_NAND: regs[a] = ~(regs[b] & regs[c]);
				OP_HALT: stopped = 1'b1;
				OP_MAP: begin
					if (regs[c] > SEGW) return F_CAPACITY;
					n = regs[c];
					if (free_cnt > 0) begin
						id = free_ids[free_cnt-1];
						free_cnt--;
					end else if (fresh_id < SEGS) begin
						id = fresh_id;
						fresh_id++;
					end else begin
						return F_CAPACITY;
					end
					for (int i = 0; i < n; i++) words[id*SEGW + i] = '0;
					seg_mapped[id] = 1'b1;
					seg_len[id] = n;
					regs[b] = id;
				end
				OP_UNMAP: begin
					if (regs[c] == 0 || regs[c] >= SEGS || !seg_mapped[regs[c]])
						return F_UNMAP;
					if (free_cnt >= SEGS) return F_CAPACITY;
					id = regs[c];
					seg_mapped[id] = 1'b0;
					seg_len[id] = 0;
					free_ids[free_cnt] = id;
					free_cnt++;
				end
				OP_OUT: begin
					if (regs[c] > BYTE_MAX) return F_OUT;
					ov = 1'b1;
					ob = regs[c][7:0];
				end
				OP_IN: begin
					it = 1'b1;
					regs[c] = eof ? 32'hFFFF_FFFF : {24'd0, ib};
				end
				OP_LOADP: begin
					if (regs[b] != 0) begin
						if (regs[b] >= SEGS || !seg_mapped[regs[b]]) return F_UNMAPPED;
						id = regs[b];
						n = seg_len[id];
						for (int i = 0; i < n; i++) words[i] = words[id*SEGW + i];
						seg_len[0] = n;
					end
					pc = regs[c];
					return F_NONE;
				end
				OP_LDI: regs[w[27:25]] = {7'd0, w[24:0]};
				default: return F_OPCODE;
			endcase
			pc++;
			return F_NONE;
		endfunction

		// accepted transfer: advance the mirror and queue what the block must report
		function void note_transfer(bit cmd, bit [31:0] w, bit [7:0] ib, bit eof);
			um_result_t r;
			bit ov, it;
			bit [7:0] ob;
			bit [3:0] f;
			ov = 1'b0;
			ob = '0;
			it = 1'b0;
			if (!stopped) begin
				if (!cmd) begin
					if (seg_len[0] >= SEGW) begin
						fcode = F_CAPACITY;
						stopped = 1'b1;
					end else begin
						words[seg_len[0]] = w;
						seg_len[0]++;
					end
				end else if (pc >= seg_len[0]) begin
					fcode = F_PC;
					stopped = 1'b1;
				end else begin
					f = run_word(words[pc], ib, eof, ov, ob, it);
					if (f != F_NONE) begin
						fcode = f;
						stopped = 1'b1;
						ov = 1'b0;
						ob = '0;
						it = 1'b0;
					end
				end
			end
			r.out_valid = ov;
			r.out_byte = ob;
			r.input_taken = it;
			r.halted = stopped;
			r.fault = fcode;
			r.next_pc = pc;
			pending.push_back(r);
		endfunction

		function void check_result(um_result_t got);
			um_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result strobe with nothing outstanding: %p", $realtime, got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch\n  expected %p\n  actual   %p",
						$realtime, want, got);
			end
		endfunction
	endclass

	um32_scoreboard sb;
	int unsigned    items;
	int unsigned    burst_left;
	longint         cycles;

	um32_instruction_executor u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.program_word(program_word),
		.in_byte     (in_byte),
		.in_eof      (in_eof),
		.done        (done),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.input_taken (input_taken),
		.halted      (halted),
		.fault       (fault),
		.next_pc     (next_pc)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// results cannot be held off: every done cycle is a transfer
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result('{out_valid, out_byte, input_taken, halted, fault, next_pc});
	end

	// One command transfer. Called at a rising edge; returns at the edge that accepted it,
	// with start still high so back-to-back transfers need no extra edge.
	task automatic xfer(bit cmd, bit [31:0] w, bit [7:0] ib, bit eof);
		int unsigned gap;
		if (burst_left == 0) begin
			// a third of the bursts follow with no gap at all
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		start <= 1'b1;
		command <= cmd;
		program_word <= w;
		in_byte <= ib;
		in_eof <= eof;
		do @(posedge clk); while (busy);
		sb.note_transfer(cmd, w, ib, eof);
		items++;
	endtask

	// append a word and execute it at once; the pc always sits at the end of the program
	task automatic run_instr(bit [31:0] w, bit eof = ($urandom_range(0, 7) == 0));
		xfer(1'b0, w, 8'($urandom), 1'($urandom));
		xfer(1'b1, 32'($urandom), 8'($urandom), eof);
	endtask

	// unused instruction bits get random content
	function automatic bit [31:0] instr(opcode_t op, bit [2:0] a, bit [2:0] b, bit [2:0] c);
		bit [18:0] junk;
		junk = 19'($urandom);
		return {op, junk, a, b, c};
	endfunction

	task automatic set_reg(bit [2:0] r, int unsigned v);
		run_instr({OP_LDI, r, 25'(v)});
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// mapped segment ids other than 0, optionally bounded in length
	function automatic int pick_segment(int unsigned min_len, int unsigned max_len);
		int q [$];
		for (int i = 1; i < SEGS; i++)
			if (sb.seg_mapped[i] && sb.seg_len[i] >= min_len && sb.seg_len[i] <= max_len)
				q.push_back(i);
		if (q.size() == 0) return -1;
		return q[$urandom_range(0, q.size() - 1)];
	endfunction

	task automatic do_unmap();
		int id;
		bit [2:0] c;
		id = pick_segment(0, SEGW);
		c = 3'($urandom);
		if (id < 0) return;
		set_reg(c, id);
		run_instr(instr(OP_UNMAP, 3'($urandom), 3'($urandom), c));
	endtask

	task automatic do_map(int unsigned size);
		bit [2:0] c;
		c = 3'($urandom);
		if (sb.free_cnt == 0 && sb.fresh_id >= SEGS) do_unmap();
		set_reg(c, size);
		run_instr(instr(OP_MAP, 3'($urandom), 3'($urandom), c));
	endtask

	// copy segment id over the program and continue right past its end
	task automatic jump_to_segment(int id);
		bit [2:0] b, c;
		b = 3'($urandom);
		c = b + 3'($urandom_range(1, 7));
		set_reg(b, id);
		if (id == 0)
			set_reg(c, sb.seg_len[0] + 2);
		else
			set_reg(c, sb.seg_len[id]);
		run_instr(instr(OP_LOADP, 3'($urandom), b, c));
	endtask

	// one instruction that cannot fault, with whatever setup it needs
	task automatic random_instr();
		bit [2:0] a, b, c;
		int id;
		a = 3'($urandom);
		b = 3'($urandom);
		c = b + 3'($urandom_range(1, 7));
		case ($urandom_range(0, 15))
			0:  run_instr(instr(OP_CMOV, a, b, c));
			1: begin
				id = pick_segment(1, SEGW);
				if ($urandom_range(0, 2) == 0 || id < 0) id = 0;
				set_reg(b, id);
				set_reg(c, $urandom_range(0, sb.seg_len[id] - 1));
				run_instr(instr(OP_LOAD, a, b, c));
			end
			2: begin
				id = pick_segment(1, SEGW);
				if (id < 0) id = 0;
				set_reg(c - 3'd1, id);
				set_reg(c, $urandom_range(0, sb.seg_len[id] - 1));
				run_instr(instr(OP_STORE, c - 3'd1, c, b));
			end
			3:  run_instr(instr(OP_ADD, a, b, c));
			4:  run_instr(instr(OP_MUL, a, b, c));
			5: begin
				if (sb.regs[c] == 0) set_reg(c, $urandom_range(1, IMM_MAX));
				run_instr(instr(OP_DIV, a, b, c));
			end
			6:  run_instr(instr(OP_NAND, a, b, c));
			7:  do_map(($urandom_range(0, 40) == 0) ? SEGW : $urandom_range(0, 8));
			8: begin
				if (pick_segment(0, SEGW) < 0) do_map($urandom_range(1, 4));
				do_unmap();
			end
			9: begin
				set_reg(c, $urandom_range(0, BYTE_MAX));
				run_instr(instr(OP_OUT, a, b, c));
			end
			10: run_instr(instr(OP_IN, a, b, c));
			11: jump_to_segment(0);
			12: begin
				id = pick_segment(0, 64);
				if (id >= 0) jump_to_segment(id);
			end
			default: set_reg(a, $urandom_range(0, IMM_MAX));
		endcase
	endtask

	// program space is finite: swap in a short segment before it fills up
	task automatic keep_program_short();
		int id;
		if (sb.seg_len[0] <= 700) return;
		id = pick_segment(0, 64);
		if (id < 0) begin
			do_map($urandom_range(0, 6));
			id = pick_segment(0, 64);
		end
		jump_to_segment(id);
	endtask

	// end the run with one way of stopping the machine, chosen at random
	task automatic stop_machine();
		bit [2:0] a, b, c;
		a = 3'($urandom);
		b = 3'($urandom);
		c = b + 3'($urandom_range(1, 7));
		case ($urandom_range(0, 9))
			0: run_instr(instr(OP_HALT, a, b, c));
			1: run_instr({4'($urandom_range(14, 15)), 28'($urandom)});
			2: begin
				// jump past the program; the fetch after it faults
				set_reg(b, 0);
				set_reg(c, $urandom_range(sb.seg_len[0] + 2, IMM_MAX));
				run_instr(instr(OP_LOADP, a, b, c));
				xfer(1'b1, 32'($urandom), 8'($urandom), 1'($urandom));
			end
			3: begin
				set_reg(c, $urandom_range(BYTE_MAX + 1, IMM_MAX));
				run_instr(instr(OP_OUT, a, b, c));
			end
			4: begin
				set_reg(c, 0);
				run_instr(instr(OP_DIV, a, b, c));
			end
			5: begin
				if (sb.fresh_id < SEGS && $urandom_range(0, 1) == 0)
					set_reg(b, sb.fresh_id);
				else
					set_reg(b, $urandom_range(SEGS, IMM_MAX));
				set_reg(c, 0);
				run_instr(instr(OP_LOAD, a, b, c));
			end
			6: begin
				// all-ones offset from an input at end of stream: unsigned compare
				set_reg(b, 0);
				if ($urandom_range(0, 1) == 0)
					run_instr(instr(OP_IN, a, b, c), 1'b1);
				else
					set_reg(c, sb.seg_len[0] + 2);
				run_instr(instr(OP_LOAD, a, b, c));
			end
			7: begin
				set_reg(c, 0);
				run_instr(instr(OP_UNMAP, a, b, c));
			end
			8: begin
				set_reg(c, $urandom_range(SEGW + 1, IMM_MAX));
				run_instr(instr(OP_MAP, a, b, c));
			end
			default: begin
				// full-size segment becomes the program, then one more append
				do_map(SEGW);
				jump_to_segment(pick_segment(SEGW, SEGW));
				xfer(1'b0, 32'($urandom), 8'($urandom), 1'($urandom));
			end
		endcase
		// a stopped machine must just repeat its status
		repeat (6) xfer(1'($urandom), 32'($urandom), 8'($urandom), 1'($urandom));
	endtask

	initial begin
		bit paused;
		sb = new();
		items = 0;
		burst_left = 0;
		paused = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = 1'b0;
		program_word = '0;
		in_byte = '0;
		in_eof = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: immediate extremes, wrapping arithmetic, both cmov outcomes,
		// a zero output, end-of-input, empty map and unmap
		set_reg(3'd7, IMM_MAX);
		set_reg(3'd0, 0);
		run_instr(instr(OP_NAND, 3'd3, 3'd0, 3'd0));
		run_instr(instr(OP_ADD, 3'd4, 3'd3, 3'd3));
		run_instr(instr(OP_MUL, 3'd2, 3'd7, 3'd7));
		run_instr(instr(OP_DIV, 3'd5, 3'd3, 3'd7));
		run_instr(instr(OP_CMOV, 3'd6, 3'd3, 3'd0));
		run_instr(instr(OP_CMOV, 3'd6, 3'd3, 3'd7));
		run_instr(instr(OP_OUT, 3'd1, 3'd1, 3'd0));
		run_instr(instr(OP_IN, 3'd1, 3'd1, 3'd1), 1'b1);
		run_instr(instr(OP_MAP, 3'd0, 3'd2, 3'd0));
		run_instr(instr(OP_UNMAP, 3'd0, 3'd0, 3'd2));

		// random phase, with one full drain halfway
		while (items < RANDOM_ITEMS) begin
			keep_program_short();
			random_instr();
			if (!paused && items > RANDOM_ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
		end

		drain();
		stop_machine();

		drain();
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
